// ===== rtl/core/sdaf_pkg.sv =====
// Shared types and constants of the signed decimal ASCII formatter.
`timescale 1ns / 1ps

package sdaf_pkg;

  // Format codes carried on the input tuser field.
  typedef enum logic [2:0] {
    FMT_PLAIN = 3'd0,
    FMT_DECI  = 3'd1,
    FMT_CENTI = 3'd2,
    FMT_MILLI = 3'd3,
    FMT_TWO   = 3'd4,
    FMT_TIME  = 3'd5,
    FMT_BOOL  = 3'd6
  } fmt_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MUL,
    FS_ADJ,
    FS_DIG,
    FS_PUSH
  } front_state_e;

  localparam int unsigned NumDigits = 5;
  localparam int unsigned DigCntW   = $clog2(NumDigits);
  localparam int unsigned MaxChars  = 7;
  localparam int unsigned CharCntW  = $clog2(MaxChars + 1);

  // Reciprocal constants: x/10 == (x*52429)>>19 for any 16-bit x,
  // m/60 == (m*34953)>>21 for any 15-bit m.
  localparam logic [15:0] DivTenMul   = 16'd52429;
  localparam int unsigned DivTenSh    = 19;
  localparam logic [15:0] DivSixtyMul = 16'd34953;
  localparam int unsigned DivSixtySh  = 21;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharPoint = 8'h2e;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharLowO  = 8'h6f;
  localparam logic [7:0] CharLowN  = 8'h6e;
  localparam logic [7:0] CharLowF  = 8'h66;

  // One converted value, handed from the front end to the emitter.
  // flag: sign for number formats, nonzero for bool.
  typedef struct packed {
    fmt_e                          fmt;
    logic                          flag;
    logic [NumDigits-1:0][3:0]     digits;  // index 0 is the ones digit
  } sdaf_item_t;

endpackage

// ===== rtl/core/sdaf_front.sv =====
// Front end: accepts values, classifies the format and extracts decimal digits.
`timescale 1ns / 1ps

module sdaf_front
  import sdaf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] value_i,
  input  logic [2:0]  format_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output sdaf_item_t  item_o
);

  front_state_e state_q, state_d;
  logic [DigCntW-1:0] dcnt_q;

  fmt_e                      fmt_q;
  logic                      flag_q;
  logic [15:0]               v_q;
  logic [9:0]                hours_q;
  logic [NumDigits-1:0][3:0] digs_q;

  fmt_e        fmt_dec;
  logic        neg_in;
  logic [15:0] mag_in;
  logic [30:0] prod60;
  logic [31:0] prod10;
  logic [12:0] quo;
  logic [15:0] rem;
  logic        accept;

  always_comb begin
    if (format_i > 3'(FMT_BOOL)) begin
      fmt_dec = FMT_PLAIN;
    end else begin
      fmt_dec = fmt_e'(format_i);
    end
  end

  assign neg_in = value_i[15];
  assign mag_in = neg_in ? (16'd0 - value_i) : value_i;  // 0x8000 stays 32768
  assign accept = in_valid_i && in_ready_o;

  // hours = minutes / 60
  assign prod60 = 31'(v_q[14:0]) * 31'(DivSixtyMul);
  // one decimal digit per step
  assign prod10 = 32'(v_q) * 32'(DivTenMul);
  assign quo    = prod10[DivTenSh +: 13];
  assign rem    = v_q - (16'({quo, 3'b000}) + 16'({quo, 1'b0}));

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    case (state_q)
      FS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (fmt_dec)
            FMT_TIME: state_d = FS_MUL;
            FMT_BOOL: state_d = FS_PUSH;
            default:  state_d = FS_DIG;
          endcase
        end
      end
      FS_MUL: state_d = FS_ADJ;
      FS_ADJ: state_d = FS_DIG;
      FS_DIG: begin
        if (dcnt_q == DigCntW'(NumDigits - 1)) state_d = FS_PUSH;
      end
      FS_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) state_d = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        dcnt_q <= '0;
      end else if (state_q == FS_DIG) begin
        dcnt_q <= dcnt_q + DigCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      FS_IDLE: begin
        if (in_valid_i) begin
          fmt_q <= fmt_dec;
          case (fmt_dec)
            FMT_TIME: begin
              flag_q <= 1'b0;
              v_q    <= neg_in ? 16'd0 : value_i;  // negative minutes read as zero
            end
            FMT_BOOL: begin
              flag_q <= (value_i != 16'd0);
              v_q    <= value_i;
            end
            default: begin
              flag_q <= neg_in;
              v_q    <= mag_in;
            end
          endcase
        end
      end
      FS_MUL: hours_q <= prod60[DivSixtySh +: 10];
      // hours*100 + minutes%60 == minutes + hours*40
      FS_ADJ: v_q <= v_q + 16'({hours_q, 5'b00000}) + 16'({hours_q, 3'b000});
      FS_DIG: begin
        v_q <= 16'(quo);
        for (int i = 0; i < NumDigits - 1; i++) begin
          digs_q[i] <= digs_q[i+1];
        end
        digs_q[NumDigits-1] <= rem[3:0];
      end
      default: ;
    endcase
  end

  assign item_o.fmt    = fmt_q;
  assign item_o.flag   = flag_q;
  assign item_o.digits = digs_q;

endmodule

// ===== rtl/core/sdaf_fifo.sv =====
// Short queue between front end and character emitter.
`timescale 1ns / 1ps

module sdaf_fifo
  import sdaf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_valid_i,
  output logic       wr_ready_o,
  input  sdaf_item_t wr_item_i,
  output logic       rd_valid_o,
  input  logic       rd_ready_i,
  output sdaf_item_t rd_item_o
);

  sdaf_item_t         ent_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]     cnt_q;
  logic               wr_en, rd_en;

  assign wr_ready_o = (cnt_q != (QPtrW+1)'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_item_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (rd_en) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + (QPtrW+1)'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - (QPtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) ent_q[wr_ptr_q] <= wr_item_i;
  end

endmodule

// ===== rtl/core/sdaf_back.sv =====
// Back end: builds the text of one value and sends it one character per beat.
`timescale 1ns / 1ps

module sdaf_back
  import sdaf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_ready_o,
  input  sdaf_item_t q_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_o,
  output logic       last_o
);

  logic [7:0]          txt_q [MaxChars];
  logic [CharCntW-1:0] rem_q;

  logic [7:0]          txt_n [MaxChars+1];
  logic [CharCntW-1:0] len_n;
  logic                on;
  logic                pop, beat;

  function automatic logic [7:0] dchar(input logic [3:0] d);
    return CharZero | {4'b0000, d};
  endfunction

  // Text assembly; len_n counts characters written so far.
  always_comb begin
    logic [NumDigits-1:0][3:0] d;
    fmt_e                      f;
    d = q_item_i.digits;
    f = q_item_i.fmt;
    for (int i = 0; i < MaxChars + 1; i++) txt_n[i] = CharZero;
    len_n = '0;
    on    = 1'b0;
    case (f)
      FMT_BOOL: begin
        txt_n[0] = CharLowO;
        if (q_item_i.flag) begin
          txt_n[1] = CharLowN;
          len_n    = CharCntW'(2);
        end else begin
          txt_n[1] = CharLowF;
          txt_n[2] = CharLowF;
          len_n    = CharCntW'(3);
        end
      end
      FMT_TIME: begin
        // hours (hundreds suppressed, tens forced), point, two-digit minutes
        if (d[4] != 4'd0) begin
          txt_n[len_n] = dchar(d[4]);
          len_n = len_n + CharCntW'(1);
        end
        txt_n[len_n] = dchar(d[3]);
        len_n = len_n + CharCntW'(1);
        txt_n[len_n] = dchar(d[2]);
        len_n = len_n + CharCntW'(1);
        txt_n[len_n] = CharPoint;
        len_n = len_n + CharCntW'(1);
        txt_n[len_n] = dchar(d[1]);
        len_n = len_n + CharCntW'(1);
        txt_n[len_n] = dchar(d[0]);
        len_n = len_n + CharCntW'(1);
      end
      default: begin
        if (q_item_i.flag) begin
          txt_n[len_n] = CharMinus;
          len_n = len_n + CharCntW'(1);
        end
        if (d[4] != 4'd0) begin
          txt_n[len_n] = dchar(d[4]);
          len_n = len_n + CharCntW'(1);
          on = 1'b1;
        end
        if (d[3] != 4'd0 || on) begin
          txt_n[len_n] = dchar(d[3]);
          len_n = len_n + CharCntW'(1);
          on = 1'b1;
        end
        if (f == FMT_MILLI) begin
          if (!on) begin
            txt_n[len_n] = CharZero;
            len_n = len_n + CharCntW'(1);
          end
          txt_n[len_n] = CharPoint;
          len_n = len_n + CharCntW'(1);
          on = 1'b1;
        end
        if (d[2] != 4'd0 || on) begin
          txt_n[len_n] = dchar(d[2]);
          len_n = len_n + CharCntW'(1);
          on = 1'b1;
        end
        if (f == FMT_CENTI) begin
          if (!on) begin
            txt_n[len_n] = CharZero;
            len_n = len_n + CharCntW'(1);
          end
          txt_n[len_n] = CharPoint;
          len_n = len_n + CharCntW'(1);
          on = 1'b1;
        end
        if (d[1] != 4'd0 || on || f == FMT_TWO) begin
          txt_n[len_n] = dchar(d[1]);
          len_n = len_n + CharCntW'(1);
          on = 1'b1;
        end
        if (f == FMT_DECI) begin
          if (!on) begin
            txt_n[len_n] = CharZero;
            len_n = len_n + CharCntW'(1);
          end
          txt_n[len_n] = CharPoint;
          len_n = len_n + CharCntW'(1);
        end
        txt_n[len_n] = dchar(d[0]);
        len_n = len_n + CharCntW'(1);
      end
    endcase
  end

  assign out_valid_o = (rem_q != '0);
  assign char_o      = txt_q[0];
  assign last_o      = (rem_q == CharCntW'(1));
  assign beat        = out_valid_o && out_ready_i;
  // take the next value when idle or as the last character leaves
  assign q_ready_o   = !out_valid_o || (beat && last_o);
  assign pop         = q_valid_i && q_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (pop) begin
      rem_q <= len_n;
    end else if (beat) begin
      rem_q <= rem_q - CharCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      for (int i = 0; i < MaxChars; i++) txt_q[i] <= txt_n[i];
    end else if (beat) begin
      for (int i = 0; i < MaxChars - 1; i++) txt_q[i] <= txt_q[i+1];
    end
  end

endmodule

// ===== rtl/core/signed_decimal_ascii_formatter.sv =====
// Top level: signed 16-bit value to decimal ASCII text (on/off in bool format), one character per beat.
// Flow: the front end takes a beat, divides by 60 in time format, extracts the
// digits (bool skips this) and queues them; the back end lays out the text, and
// the characters follow one per cycle while the sink is ready. The digit unit works
// on one value at a time, overlapped with emission of the previous text (1 to 7 characters).
// Reset (async, active low) empties the queue and returns both ends to idle.
`timescale 1ns / 1ps

module signed_decimal_ascii_formatter
  import sdaf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] value (signed)
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] format
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] char_out
  output logic        m_axis_tlast_o    // last character of the text
);

  logic       push_valid, push_ready;
  sdaf_item_t push_item;
  logic       q_valid, q_ready;
  sdaf_item_t q_item;

  // Front: takes a beat, runs the divide-by-60 step for time format and
  // pulls out five digits (not in bool format) with a reciprocal multiply, one digit per cycle.
  sdaf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .value_i      (s_axis_tdata_i),
    .format_i     (s_axis_tuser_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  // Two-entry queue so the digit unit keeps working while text drains.
  sdaf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_item_i  (push_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  // Back: lays out sign, digits and decimal point, then shifts them out.
  sdaf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .char_o      (m_axis_tdata_o),
    .last_o      (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  // Front works on one value at a time.
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("front accepted a beat while converting");

  // Emitter picks up a queued value in the next cycle when idle.
  a_back_pickup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !m_axis_tvalid_o) |=> m_axis_tvalid_o)
    else $error("queued value not picked up");

  // Output goes idle after the final character when nothing is queued.
  a_back_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o && !q_valid)
      |=> !m_axis_tvalid_o)
    else $error("output still valid after last character");
`endif

endmodule
